/* design/rbbf_pkg.sv */
`timescale 1ns / 1ps
package rbbf_pkg;

    localparam int PIX_W        = 8;
    localparam int CFG_W        = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int ROW_W        = 12;
    localparam int HEIGHT_W     = 13;
    localparam int HEIGHT_LIMIT = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    // One stored pixel, laid out as blue in the low byte.
    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_t;

endpackage

/* design/rgb_box_blur_filter_top.sv */
`timescale 1ns / 1ps
// Streaming RGB box blur. Pixels enter in raster order, one word per pixel, and
// leave r*W + r pixels later as the floor of the mean over a (2r+1) by (2r+1)
// window; pixels within r of a frame edge are passed through unchanged. The rows
// live in a single-port-read line store of 2*MAX_RADIUS+1 lines. A word that
// produces no result is only accepted. A word that produces a pass-through
// result steps through accept, read, drain and send. A word that produces a
// blurred result steps through accept, the window reads in turn through the
// line store read port, a drain of the last read, the reciprocal multiply that
// forms the mean, a wait for it, and send. A result that finds the previous
// output word still stalled waits in the send step, and the input stays
// stalled meanwhile. Flush words drain the tail of a finished frame, one result
// each, and frame_last marks the last pixel.
// Any register write restarts the stream and drops an undrained tail.
module rgb_box_blur_filter_top
    import rbbf_pkg::*;
#(
    parameter int MAX_RADIUS = 3,
    parameter int MAX_WIDTH  = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [PIX_W-1:0]     blue_in,
    input  logic [PIX_W-1:0]     green_in,
    input  logic [PIX_W-1:0]     red_in,
    input  logic                 flush,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [PIX_W-1:0]     blue_out,
    output logic [PIX_W-1:0]     green_out,
    output logic [PIX_W-1:0]     red_out,
    output logic                 frame_last,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int RING     = 2 * MAX_RADIUS + 1;
    localparam int SLOT_W   = $clog2(RING);
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int WID_W    = $clog2(MAX_WIDTH + 1);
    localparam int R_W      = $clog2(MAX_RADIUS + 1);
    localparam int SIDE_W   = $clog2(RING + 1);
    localparam int AREA_MAX = RING * RING;
    localparam int AREA_W   = $clog2(AREA_MAX + 1);
    localparam int SUM_W    = $clog2(AREA_MAX * 255 + 1);
    localparam int DEPTH    = RING * MAX_WIDTH;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int LAG_MAX  = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS;
    localparam int PEND_W   = $clog2(LAG_MAX + 2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SEND
    } state_t;

    state_t state_reg;

    logic [1:0]          radius_reg;
    logic [10:0]         width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    logic [COL_W-1:0]  in_col_reg;
    logic [ROW_W-1:0]  in_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [SLOT_W-1:0] wr_slot_reg;
    logic [SLOT_W-1:0] rd_slot_reg;
    logic [PEND_W-1:0] pending_reg;

    // Window walk.
    logic [SLOT_W-1:0] slot_reg;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_start_reg;
    logic [SIDE_W-1:0] dx_reg;
    logic [SIDE_W-1:0] dy_reg;
    logic              copy_reg;
    logic              rd_valid_reg;
    logic              last_reg;
    logic [2:0][SUM_W-1:0] sum_reg;

    logic              out_valid_reg;
    logic [PIX_W-1:0]  blue_reg;
    logic [PIX_W-1:0]  green_reg;
    logic [PIX_W-1:0]  red_reg;
    logic              last_out_reg;

    // Effective configuration after clamping.
    logic [3:0]          rad_ext;
    logic [12:0]         wid_ext;
    logic [R_W-1:0]      r_eff;
    logic [WID_W-1:0]    w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [PEND_W-1:0]   lag;
    logic [SIDE_W-1:0]   side;
    logic [AREA_W-1:0]   area;

    assign rad_ext = {2'b00, radius_reg};
    assign wid_ext = {2'b00, width_reg};
    assign r_eff   = (rad_ext > 4'(MAX_RADIUS)) ? R_W'(MAX_RADIUS) : R_W'(rad_ext);
    assign w_eff   = (wid_ext == 13'd0) ? WID_W'(1) :
                     (wid_ext > 13'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : WID_W'(wid_ext);
    assign h_eff   = (height_reg == '0) ? HEIGHT_W'(1) :
                     (height_reg > HEIGHT_W'(HEIGHT_LIMIT)) ? HEIGHT_W'(HEIGHT_LIMIT) :
                     height_reg;
    assign lag     = PEND_W'(r_eff) * PEND_W'(w_eff) + PEND_W'(r_eff);
    assign side    = SIDE_W'({r_eff, 1'b1});
    assign area    = AREA_W'(side) * AREA_W'(side);

    logic accept;
    logic pixel;
    logic emit_pixel;
    logic emit_flush;
    logic [PEND_W-1:0] pending_inc;

    assign accept      = in_valid && !in_stall;
    assign pixel       = accept && !flush;
    assign pending_inc = pending_reg + 1'b1;
    assign emit_pixel  = pixel && (pending_inc > lag);
    assign emit_flush  = accept && flush && (in_col_reg == '0) && (in_row_reg == '0) &&
                         (pending_reg != '0);

    // Is the output position an interior pixel, and is it the frame's last one.
    logic interior;
    logic at_last;
    logic [SLOT_W+1:0] slot_sum;
    logic [SLOT_W-1:0] slot_first;

    assign interior = (out_row_reg >= ROW_W'(r_eff)) &&
                      (HEIGHT_W'(out_row_reg) + HEIGHT_W'(r_eff) < h_eff) &&
                      (out_col_reg >= COL_W'(r_eff)) &&
                      ((WID_W + 1)'(out_col_reg) + (WID_W + 1)'(r_eff) <
                       (WID_W + 1)'(w_eff));
    assign at_last  = (HEIGHT_W'(out_row_reg) == h_eff - 1'b1) &&
                      (WID_W'(out_col_reg) == w_eff - 1'b1);
    assign slot_sum = (SLOT_W + 2)'(rd_slot_reg) + (SLOT_W + 2)'(RING) -
                      (SLOT_W + 2)'(r_eff);
    assign slot_first = (slot_sum >= (SLOT_W + 2)'(RING)) ?
                        SLOT_W'(slot_sum - (SLOT_W + 2)'(RING)) : SLOT_W'(slot_sum);

    // Line store.
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;
    rgb_t              wr_data;
    rgb_t              rd_data;

    assign wr_addr = ADDR_W'(ADDR_W'(wr_slot_reg) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(in_col_reg);
    assign rd_addr = ADDR_W'(ADDR_W'(slot_reg) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(col_reg);
    assign rd_en   = (state_reg == ST_READ);
    assign wr_data = '{red: red_in, green: green_in, blue: blue_in};

    rbbf_line_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (pixel),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Divider.
    logic                  div_start;
    logic                  div_done;
    logic [2:0][PIX_W-1:0] quotient;

    assign div_start = (state_reg == ST_DIV_START);

    rbbf_div #(
        .SUM_W  (SUM_W),
        .AREA_W (AREA_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (area),
        .dividend (sum_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    logic send_ok;
    logic last_issue;

    assign send_ok    = !out_valid_reg || !out_stall;
    assign last_issue = copy_reg || ((dx_reg == side - 1'b1) && (dy_reg == side - 1'b1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radius_reg    <= 2'd1;
            width_reg     <= 11'd640;
            height_reg    <= HEIGHT_W'(480);
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            wr_slot_reg   <= '0;
            rd_slot_reg   <= '0;
            pending_reg   <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            slot_reg      <= '0;
            col_reg       <= '0;
            col_start_reg <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            copy_reg      <= 1'b0;
            last_reg      <= 1'b0;
            sum_reg       <= '0;
            blue_reg      <= '0;
            green_reg     <= '0;
            red_reg       <= '0;
            last_out_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            rd_valid_reg <= rd_en;
            if (rd_valid_reg)
            begin
                sum_reg[0] <= sum_reg[0] + SUM_W'(rd_data.blue);
                sum_reg[1] <= sum_reg[1] + SUM_W'(rd_data.green);
                sum_reg[2] <= sum_reg[2] + SUM_W'(rd_data.red);
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pixel)
                    begin
                        pending_reg <= pending_inc;
                        if (WID_W'(in_col_reg) + 1'b1 >= w_eff)
                        begin
                            in_col_reg  <= '0;
                            wr_slot_reg <= (wr_slot_reg == SLOT_W'(RING - 1)) ?
                                           '0 : wr_slot_reg + 1'b1;
                            in_row_reg  <= (HEIGHT_W'(in_row_reg) + 1'b1 >= h_eff) ?
                                           '0 : in_row_reg + 1'b1;
                        end
                        else
                        begin
                            in_col_reg <= in_col_reg + 1'b1;
                        end
                    end
                    if (emit_pixel || emit_flush)
                    begin
                        // Set up the window walk, or a single read for a border pixel.
                        sum_reg       <= '0;
                        dx_reg        <= '0;
                        dy_reg        <= '0;
                        copy_reg      <= !interior;
                        last_reg      <= at_last;
                        slot_reg      <= interior ? slot_first : rd_slot_reg;
                        col_reg       <= interior ? COL_W'(out_col_reg - COL_W'(r_eff)) :
                                         out_col_reg;
                        col_start_reg <= COL_W'(out_col_reg - COL_W'(r_eff));
                        state_reg     <= ST_READ;
                    end
                end

                ST_READ:
                begin
                    if (last_issue)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else if (dx_reg == side - 1'b1)
                    begin
                        dx_reg   <= '0;
                        dy_reg   <= dy_reg + 1'b1;
                        col_reg  <= col_start_reg;
                        slot_reg <= (slot_reg == SLOT_W'(RING - 1)) ? '0 : slot_reg + 1'b1;
                    end
                    else
                    begin
                        dx_reg  <= dx_reg + 1'b1;
                        col_reg <= col_reg + 1'b1;
                    end
                end

                ST_DRAIN:
                begin
                    state_reg <= copy_reg ? ST_SEND : ST_DIV_START;
                end

                ST_DIV_START:
                begin
                    state_reg <= ST_DIV_WAIT;
                end

                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_SEND;
                    end
                end

                ST_SEND:
                begin
                    if (send_ok)
                    begin
                        out_valid_reg <= 1'b1;
                        last_out_reg  <= last_reg;
                        if (copy_reg)
                        begin
                            blue_reg  <= sum_reg[0][PIX_W-1:0];
                            green_reg <= sum_reg[1][PIX_W-1:0];
                            red_reg   <= sum_reg[2][PIX_W-1:0];
                        end
                        else
                        begin
                            blue_reg  <= quotient[0];
                            green_reg <= quotient[1];
                            red_reg   <= quotient[2];
                        end
                        pending_reg <= pending_reg - 1'b1;
                        if (WID_W'(out_col_reg) + 1'b1 >= w_eff)
                        begin
                            out_col_reg <= '0;
                            rd_slot_reg <= (rd_slot_reg == SLOT_W'(RING - 1)) ?
                                           '0 : rd_slot_reg + 1'b1;
                            out_row_reg <= (HEIGHT_W'(out_row_reg) + 1'b1 >= h_eff) ?
                                           '0 : out_row_reg + 1'b1;
                        end
                        else
                        begin
                            out_col_reg <= out_col_reg + 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // A register write restarts the stream.
            if (cfg_write &&
                (cfg_index == REG_RADIUS || cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT))
            begin
                unique case (cfg_index)
                    REG_RADIUS: radius_reg <= cfg_data[1:0];
                    REG_WIDTH:  width_reg  <= cfg_data[10:0];
                    REG_HEIGHT: height_reg <= cfg_data;
                    default:    radius_reg <= radius_reg;
                endcase
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
                wr_slot_reg <= '0;
                rd_slot_reg <= '0;
                pending_reg <= '0;
            end
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign blue_out   = blue_reg;
    assign green_out  = green_reg;
    assign red_out    = red_reg;
    assign frame_last = last_out_reg;

    // Read data only comes back while the window walk is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == ST_READ || state_reg == ST_DRAIN))
        else $error("line store data returned outside the window walk");

    // The divider finishes only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished while not awaited");

    // A new result is loaded only from the send step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_SEND))
        else $error("result loaded outside the send step");

endmodule

/* design/rbbf_line_store.sv */
`timescale 1ns / 1ps
module rbbf_line_store
    import rbbf_pkg::*;
#(
    parameter int DEPTH  = 7168,
    parameter int ADDR_W = 13
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  rgb_t              wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output rgb_t              rd_data
);

    rgb_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* design/rbbf_div.sv */
`timescale 1ns / 1ps
module rbbf_div
    import rbbf_pkg::*;
#(
    parameter int SUM_W  = 14,
    parameter int AREA_W = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [AREA_W-1:0]     divisor,
    input  logic [2:0][SUM_W-1:0] dividend,
    output logic [2:0][PIX_W-1:0] quotient,
    output logic                  done
);

    localparam int RECIP_W = 25;
    localparam int SHIFT   = 24;
    localparam int PROD_W  = SUM_W + RECIP_W;

    // Scaled reciprocals of the four window areas, rounded up.
    localparam logic [RECIP_W-1:0] RECIP_1  = 25'd16777216;
    localparam logic [RECIP_W-1:0] RECIP_9  = 25'd1864136;
    localparam logic [RECIP_W-1:0] RECIP_25 = 25'd671089;
    localparam logic [RECIP_W-1:0] RECIP_49 = 25'd342393;

    logic [RECIP_W-1:0]     recip;
    logic [2:0][PROD_W-1:0] product;
    logic [2:0][PIX_W-1:0]  quo_reg;
    logic                   done_reg;

    // The rounding error of each reciprocal stays small enough that the
    // product gives the exact floor for every sum a window can reach.
    always_comb
    begin
        unique case (divisor)
            AREA_W'(1):  recip = RECIP_1;
            AREA_W'(9):  recip = RECIP_9;
            AREA_W'(25): recip = RECIP_25;
            default:     recip = RECIP_49;
        endcase
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            product[c] = PROD_W'(dividend[c]) * PROD_W'(recip);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
            if (start)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    quo_reg[c] <= product[c][SHIFT +: PIX_W];
                end
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule
